// File: rtl/itd_pkg.sv
// shared types and constants of the tap detector
package itd_pkg;

    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int THR_W   = 15;
    localparam int GATE_W  = 16;
    localparam int DT_W    = 20;
    localparam int TIME_W  = 32;
    localparam int GYRO_W  = 17;
    localparam int SHOCK_W = 21;
    localparam int ALPHA_W = 16;
    localparam int ALPHA_BITS = 15;
    localparam int DEN_W   = 21;
    localparam int NUM_W   = 36;
    localparam int ADDR_W  = 3;

    localparam logic [THR_W-1:0]   THR_RESET  = 15'd1500;
    localparam logic [GATE_W-1:0]  GATE_RESET = 16'd1000;
    localparam int                 BASE_RESET_MG = 1000;
    localparam logic [TIME_W-1:0]  REFR_RESET = 32'd250;
    localparam logic [TIME_W-1:0]  REINIT_HOLD_MS = 32'd250;
    localparam logic [TIME_W-1:0]  TAP_HOLD_MS = 32'd100;
    localparam logic [DEN_W-1:0]   TAU_US = 21'd500000;
    localparam logic [SHOCK_W-1:0] SHOCK_MAX = 21'd2097151;
    localparam logic [SHOCK_W-1:0] TAP_MAX_US = 21'd250000;
    localparam logic [SHOCK_W-1:0] ABANDON_US = 21'd500000;
    localparam logic [GYRO_W-1:0]  GYRO_MAX = 17'd131071;

    localparam logic [ADDR_W-1:0] ADDR_THR  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_GATE = 3'd4;

    typedef enum logic [1:0] {
        MODE_ACCEL  = 2'd0,
        MODE_GYRO   = 2'd1,
        MODE_REINIT = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DIV,
        S_MUL,
        S_UPDATE,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start_root;
        logic start_div;
    } t_seq_ctl;

endpackage

// File: rtl/imu_tap_detector.sv
// top level of the accelerometer tap detector
// One request is taken at a time: o_s_tready is high only while the block
// is idle. An accelerometer sample runs from acceptance to a valid result
// through the squaring of its three axes through one multiplier, the
// bit-serial square root, the smoothing-factor divider, the shift-add
// baseline multiply, and the states that update, decide and register the
// result. A gyro sample stops after the square root; a re-init event or an
// ignored sample goes straight from idle to the done state. The result
// waits in an output register until taken, and the next request can be taken
// in the cycle the result shows up, or else once the waiting result is taken.
module imu_tap_detector #(
    parameter int BASELINE_FRAC_BITS = itd_pkg::DEF_FRAC_BITS,
    parameter int SAMPLE_WIDTH       = itd_pkg::DEF_SAMPLE_WIDTH,
    parameter int IN_TDATA_W         = ((3 * SAMPLE_WIDTH + itd_pkg::DT_W
                                         + itd_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // vec_x, vec_y, vec_z, sample_period_us, now_ms
    input  logic [IN_TDATA_W-1:0]       i_s_tdata,
    // mode, calibrating
    input  logic [2:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // tap_seen, shock_active
    output logic [7:0]                  o_m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int SW  = SAMPLE_WIDTH;
    localparam int FB  = BASELINE_FRAC_BITS;
    localparam int NW  = 2 * SW + 2;
    localparam int MW  = SW + 1;
    localparam int BW  = MW + FB;
    localparam int AW  = BW + itd_pkg::ALPHA_W;
    localparam int CW  = ((MW > itd_pkg::THR_W) ? MW : itd_pkg::THR_W) + FB + 1;
    localparam int GXW = (MW > itd_pkg::GYRO_W) ? MW : itd_pkg::GYRO_W;
    localparam int DO  = 3 * SW;
    localparam int TO  = DO + itd_pkg::DT_W;

    itd_pkg::t_state   r_state, n_state;
    itd_pkg::t_seq_ctl ctl;

    logic [itd_pkg::THR_W-1:0]   r_thr;
    logic [itd_pkg::GATE_W-1:0]  r_gate;

    logic [1:0]                  r_mode;
    logic [SW-1:0]               r_ax, r_ay, r_az;
    logic [itd_pkg::DT_W-1:0]    r_dt;
    logic [itd_pkg::TIME_W-1:0]  r_now;
    logic [NW-1:0]               r_sum;
    logic [1:0]                  r_idx;
    logic [MW-1:0]               r_mag;
    logic [itd_pkg::ALPHA_W-1:0] r_alpha;
    logic [BW-1:0]               r_diff;
    logic                        r_up;
    logic [AW-1:0]               r_acc;
    logic [3:0]                  r_bit;
    logic                        r_tap;

    logic [BW-1:0]                r_base;
    logic [itd_pkg::GYRO_W-1:0]   r_gyro;
    logic                         r_shock;
    logic [itd_pkg::SHOCK_W-1:0]  r_stime;
    logic [itd_pkg::TIME_W-1:0]   r_refr;

    logic                        r_ovalid;
    logic                        r_otap;
    logic                        r_oshock;

    logic                        root_done;
    logic [MW-1:0]               root;
    logic                        div_done;
    logic [itd_pkg::ALPHA_W-1:0] alpha;

    logic                        in_acc;
    logic                        cfg_wr;
    logic [SW-1:0]               sq_in;
    logic [2*SW-1:0]             sq;
    logic [BW-1:0]               target;
    logic [BW-1:0]               step;
    logic [BW-1:0]               dev;
    logic [CW-1:0]               dev_x, thr_x, half_x;
    logic [itd_pkg::SHOCK_W:0]   stime_sum;
    logic [itd_pkg::SHOCK_W-1:0] stime_sat;
    logic [itd_pkg::TIME_W-1:0]  win_diff;
    logic                        out_free;

    function automatic logic [SW-1:0] abs_s(input logic [SW-1:0] v);
        abs_s = v[SW-1] ? SW'(~v + 1'b1) : v;
    endfunction

    function automatic logic [BW-1:0] BASE_RESET_SCALED();
        BASE_RESET_SCALED = BW'(itd_pkg::BASE_RESET_MG) << FB;
    endfunction

    assign in_acc   = i_s_tvalid && o_s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_free = !r_ovalid || i_m_tready;

    assign o_s_tready = (r_state == itd_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_oshock, r_otap};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= itd_pkg::THR_RESET;
            r_gate <= itd_pkg::GATE_RESET;
        end else if (cfg_wr) begin
            unique case (paddr)
                itd_pkg::ADDR_THR:  r_thr  <= pwdata[itd_pkg::THR_W-1:0];
                itd_pkg::ADDR_GATE: r_gate <= pwdata[itd_pkg::GATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            itd_pkg::ADDR_THR:  prdata = {17'd0, r_thr};
            itd_pkg::ADDR_GATE: prdata = {16'd0, r_gate};
            default:            prdata = 32'd0;
        endcase
    end

    itd_isqrt #(.NW(NW)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_radicand (r_sum),
        .o_done     (root_done),
        .o_root     (root)
    );

    itd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_dt    (r_dt),
        .o_done  (div_done),
        .o_alpha (alpha)
    );

    always_comb begin
        unique case (r_idx)
            2'd0:    sq_in = r_ax;
            2'd1:    sq_in = r_ay;
            default: sq_in = r_az;
        endcase
    end
    assign sq = sq_in * sq_in;

    assign target = {r_mag, {FB{1'b0}}};
    // round the scaled product back by the 15 fraction bits of alpha
    assign step   = BW'((r_acc + AW'(1 << (itd_pkg::ALPHA_BITS - 1)))
                        >> itd_pkg::ALPHA_BITS);
    assign dev    = (target >= r_base) ? BW'(target - r_base) : BW'(r_base - target);
    assign dev_x  = CW'(dev);
    assign thr_x  = CW'(r_thr) << FB;
    assign half_x = CW'(r_thr) << (FB - 1);

    assign stime_sum = {1'b0, r_stime} + (itd_pkg::SHOCK_W + 1)'(r_dt);
    assign stime_sat = stime_sum[itd_pkg::SHOCK_W] ? itd_pkg::SHOCK_MAX
                                                   : stime_sum[itd_pkg::SHOCK_W-1:0];
    assign win_diff  = r_now - r_refr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        unique case (r_state)
            itd_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_s_tuser[1:0] == itd_pkg::MODE_ACCEL && !i_s_tuser[2])
                        || i_s_tuser[1:0] == itd_pkg::MODE_GYRO) begin
                        n_state = itd_pkg::S_SQUARE;
                    end else begin
                        n_state = itd_pkg::S_DONE;
                    end
                end
            end
            itd_pkg::S_SQUARE: begin
                if (r_idx == 2'd3) begin
                    ctl.start_root = 1'b1;
                    n_state = itd_pkg::S_ROOT;
                end
            end
            itd_pkg::S_ROOT: begin
                if (root_done) begin
                    if (r_mode == itd_pkg::MODE_GYRO) begin
                        n_state = itd_pkg::S_DONE;
                    end else begin
                        ctl.start_div = 1'b1;
                        n_state = itd_pkg::S_DIV;
                    end
                end
            end
            itd_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = itd_pkg::S_MUL;
                end
            end
            itd_pkg::S_MUL: begin
                if (r_bit == 4'd0) begin
                    n_state = itd_pkg::S_UPDATE;
                end
            end
            itd_pkg::S_UPDATE: n_state = itd_pkg::S_DECIDE;
            itd_pkg::S_DECIDE: n_state = itd_pkg::S_DONE;
            itd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = itd_pkg::S_IDLE;
                end
            end
            default: n_state = itd_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            itd_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_mode <= i_s_tuser[1:0];
                    r_ax   <= abs_s(i_s_tdata[SW-1:0]);
                    r_ay   <= abs_s(i_s_tdata[2*SW-1:SW]);
                    r_az   <= abs_s(i_s_tdata[3*SW-1:2*SW]);
                    r_dt   <= i_s_tdata[TO-1:DO];
                    r_now  <= i_s_tdata[TO+itd_pkg::TIME_W-1:TO];
                    r_sum  <= '0;
                    r_idx  <= 2'd0;
                    r_tap  <= 1'b0;
                end
            end
            itd_pkg::S_SQUARE: begin
                if (r_idx != 2'd3) begin
                    r_sum <= r_sum + NW'(sq);
                end
                r_idx <= r_idx + 1'b1;
            end
            itd_pkg::S_ROOT: begin
                if (root_done) begin
                    r_mag <= root;
                end
            end
            itd_pkg::S_DIV: begin
                if (div_done) begin
                    r_alpha <= alpha;
                    r_up    <= target >= r_base;
                    r_diff  <= (target >= r_base) ? BW'(target - r_base)
                                                  : BW'(r_base - target);
                    r_acc   <= '0;
                    r_bit   <= 4'd15;
                end
            end
            itd_pkg::S_MUL: begin
                r_acc <= AW'(r_acc << 1) + (r_alpha[r_bit] ? AW'(r_diff) : AW'(0));
                r_bit <= r_bit - 1'b1;
            end
            // a tap is a shock that closed early enough in this request
            itd_pkg::S_DECIDE: begin
                r_tap <= r_shock && dev_x < half_x && stime_sat < itd_pkg::TAP_MAX_US;
            end
            default: ;
        endcase
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BW'(BASE_RESET_SCALED());
            r_gyro  <= '0;
            r_shock <= 1'b0;
            r_stime <= '0;
            r_refr  <= itd_pkg::REFR_RESET;
        end else begin
            unique case (r_state)
                itd_pkg::S_ROOT: begin
                    if (root_done && r_mode == itd_pkg::MODE_GYRO) begin
                        r_gyro <= (GXW'(root) > GXW'(itd_pkg::GYRO_MAX))
                                  ? itd_pkg::GYRO_MAX : itd_pkg::GYRO_W'(root);
                    end
                end
                itd_pkg::S_UPDATE: begin
                    r_base <= r_up ? r_base + step : r_base - step;
                end
                itd_pkg::S_DECIDE: begin
                    if (!r_shock) begin
                        if (!win_diff[itd_pkg::TIME_W-1]
                            && r_gyro <= {1'b0, r_gate} && dev_x > thr_x) begin
                            r_shock <= 1'b1;
                            r_stime <= itd_pkg::SHOCK_W'(r_dt);
                        end
                    end else begin
                        r_stime <= stime_sat;
                        if (dev_x < half_x) begin
                            r_shock <= 1'b0;
                            if (stime_sat < itd_pkg::TAP_MAX_US) begin
                                r_refr <= r_now + itd_pkg::TAP_HOLD_MS;
                            end
                        end else if (stime_sat > itd_pkg::ABANDON_US) begin
                            r_shock <= 1'b0;
                        end
                    end
                end
                itd_pkg::S_DONE: begin
                    if (out_free && r_mode == itd_pkg::MODE_REINIT) begin
                        r_base  <= BW'(BASE_RESET_SCALED());
                        r_gyro  <= '0;
                        r_shock <= 1'b0;
                        r_stime <= '0;
                        r_refr  <= r_now + itd_pkg::REINIT_HOLD_MS;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: valid, tap flag and shock flag for this request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_otap   <= 1'b0;
            r_oshock <= 1'b0;
        end else begin
            if (r_state == itd_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                r_otap   <= r_tap;
                r_oshock <= (r_mode == itd_pkg::MODE_REINIT) ? 1'b0 : r_shock;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/itd_isqrt.sv
// iterative rounded square root, two radicand bits per cycle
module itd_isqrt #(
    parameter int NW = 34
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itd_pkg::t_seq_ctl     i_ctl,
    input  logic [NW-1:0]         i_radicand,
    output logic                  o_done,
    output logic [NW/2-1:0]       o_root
);
    localparam int H  = NW / 2;
    localparam int CW = $clog2(H + 1);

    logic [NW-1:0]  r_rad;
    logic [H:0]     r_rem;
    logic [H-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [H+2:0]   shifted;
    logic [H+2:0]   trial;
    logic           fits;
    logic           round_up;

    assign shifted  = {r_rem, r_rad[NW-1:NW-2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign fits     = shifted >= trial;
    assign round_up = {1'b0, r_rem} > {2'b00, r_root};
    assign o_root   = r_root + {{(H-1){1'b0}}, round_up};
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start_root) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[NW-3:0], 2'b00};
                if (fits) begin
                    r_rem  <= (H+1)'(shifted - trial);
                    r_root <= {r_root[H-2:0], 1'b1};
                end else begin
                    r_rem  <= (H+1)'(shifted);
                    r_root <= {r_root[H-2:0], 1'b0};
                end
                if (r_cnt == CW'(H - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// File: rtl/itd_div.sv
// restoring divider for the rounded smoothing factor
module itd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itd_pkg::t_seq_ctl             i_ctl,
    input  logic [itd_pkg::DT_W-1:0]      i_dt,
    output logic                          o_done,
    output logic [itd_pkg::ALPHA_W-1:0]   o_alpha
);
    localparam int QW = itd_pkg::ALPHA_W;
    localparam int DW = itd_pkg::DEN_W;
    localparam int NW = itd_pkg::NUM_W;

    logic [DW-1:0]   den;
    logic [NW-1:0]   num;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_low;
    logic [QW-1:0]   r_quo;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DW:0]     shifted;
    logic            fits;

    assign den = itd_pkg::TAU_US + DW'(i_dt);
    // dt * 2^15 plus half the divisor, so the quotient is rounded
    assign num = {1'b0, i_dt, 15'd0} + NW'(den >> 1);

    assign shifted = {r_rem, r_low[QW-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign o_alpha = r_quo;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start_div) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= den;
                r_rem  <= DW'(num[NW-1:QW]);
                r_low  <= num[QW-1:0];
                r_quo  <= '0;
            end else if (r_busy) begin
                r_low <= {r_low[QW-2:0], 1'b0};
                if (fits) begin
                    r_rem <= DW'(shifted - {1'b0, r_den});
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= DW'(shifted);
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                if (r_cnt == 5'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// File: rtl/itd_checker.sv
// port-level checks of the tap detector, bound to the top level
module itd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);
    // a finished result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before it was taken");

    // one request at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while the previous one is in work");

    // a tap always closes the shock
    a_tap_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> !o_m_tdata[1])
        else $error("tap reported with shock still active");

    // no result can appear in the cycle right after a request
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");

endmodule

bind imu_tap_detector itd_checker u_itd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
